@@ sv/cs2sj_pkg.sv @@
// cs2sj_pkg: shared word width, beat types and status codes for the
// cartesian-to-spherical jacobian block. No dependencies.
`default_nettype none
package cs2sj_pkg;

  localparam int CS_W        = 32;   // data word width of the coordinate and result fields
  localparam int CS_FRAC_DEF = 16;   // default fraction bits

  localparam logic [1:0] ST_OK          = 2'b00;
  localparam logic [1:0] ST_RADIUS_ZERO = 2'b01;
  localparam logic [1:0] ST_POLAR_AXIS  = 2'b10;

  typedef struct packed {
    logic signed [CS_W-1:0] coord_x;
    logic signed [CS_W-1:0] coord_y;
    logic signed [CS_W-1:0] coord_z;
    logic        [CS_W-2:0] radius;
  } in_beat_t;

  typedef struct packed {
    logic signed [CS_W-1:0] dr_dx;
    logic signed [CS_W-1:0] dtheta_dx;
    logic signed [CS_W-1:0] dphi_dx;
    logic signed [CS_W-1:0] dr_dy;
    logic signed [CS_W-1:0] dtheta_dy;
    logic signed [CS_W-1:0] dphi_dy;
    logic signed [CS_W-1:0] dr_dz;
    logic signed [CS_W-1:0] dtheta_dz;
    logic        [1:0]      status;
  } out_beat_t;

endpackage
`default_nettype wire

@@ sv/cs2sj_sqrt.sv @@
// cs2sj_sqrt: pipelined integer square root, one result bit per stage,
// with a sideband carried alongside. No dependencies.
`default_nettype none
module cs2sj_sqrt #(
  parameter int SQ_W = 64,   // radicand width
  parameter int RES_W = 32,  // root width
  parameter int SB_W = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [SQ_W-1:0]  in_s,
  input  wire logic [SB_W-1:0]  in_sb,
  output logic                  out_vld,
  output logic [RES_W-1:0]      out_root,
  output logic [SB_W-1:0]       out_sb
);

  localparam int TW = SQ_W + 1;

  logic [SQ_W-1:0]  rem_r [RES_W];
  logic [RES_W-1:0] res_r [RES_W];
  logic [SB_W-1:0]  sb_r  [RES_W];
  logic             vld_r [RES_W];

  for (genvar k = 0; k < RES_W; k++) begin : g_stage
    localparam int B = RES_W - 1 - k;
    logic [SQ_W-1:0]  rem_in;
    logic [RES_W-1:0] res_in;
    logic [SB_W-1:0]  sb_in;
    logic             vld_in;
    logic [TW-1:0]    trial;
    logic             take;
    logic [SQ_W-1:0]  rem_nxt;
    logic [RES_W-1:0] res_nxt;

    if (k == 0) begin : g_first
      assign rem_in = in_s;
      assign res_in = '0;
      assign sb_in  = in_sb;
      assign vld_in = in_vld;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
      assign sb_in  = sb_r[k-1];
      assign vld_in = vld_r[k-1];
    end

    // (res + 2^b)^2 - res^2 = res*2^(b+1) + 2^(2b)
    assign trial   = (TW'(res_in) << (B + 1)) | (TW'(1) << (2 * B));
    assign take    = TW'(rem_in) >= trial;
    assign rem_nxt = take ? SQ_W'(TW'(rem_in) - trial) : rem_in;
    assign res_nxt = take ? (res_in | (RES_W'(1) << B)) : res_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        res_r[k] <= res_nxt;
        sb_r[k]  <= sb_in;
      end
    end
  end

  assign out_vld  = vld_r[RES_W-1];
  assign out_root = res_r[RES_W-1];
  assign out_sb   = sb_r[RES_W-1];

endmodule
`default_nettype wire

@@ sv/cs2sj_div.sv @@
// cs2sj_div: pipelined restoring divider, one quotient bit per stage,
// quotient forced to all ones when it does not fit. No dependencies.
`default_nettype none
module cs2sj_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 94,
  parameter int Q_W = 32,
  parameter int SB_W = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [NUM_W-1:0] in_num,
  input  wire logic [DEN_W-1:0] in_den,
  input  wire logic [SB_W-1:0]  in_sb,
  output logic                  out_vld,
  output logic [Q_W-1:0]        out_mag,
  output logic [SB_W-1:0]       out_sb
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [CW-1:0]    rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic             ovf_r [Q_W];
  logic [SB_W-1:0]  sb_r  [Q_W];
  logic             vld_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic [CW-1:0]    rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic             ovf_in;
    logic [SB_W-1:0]  sb_in;
    logic             vld_in;
    logic [CW-1:0]    trial;
    logic             take;
    logic [CW-1:0]    rem_nxt;
    logic [Q_W-1:0]   q_nxt;

    if (k == 0) begin : g_first
      assign rem_in = CW'(in_num);
      assign den_in = in_den;
      assign q_in   = '0;
      // quotient reaches 2^Q_W
      assign ovf_in = CW'(in_num) >= (CW'(in_den) << Q_W);
      assign sb_in  = in_sb;
      assign vld_in = in_vld;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
      assign ovf_in = ovf_r[k-1];
      assign sb_in  = sb_r[k-1];
      assign vld_in = vld_r[k-1];
    end

    assign trial   = CW'(den_in) << B;
    assign take    = rem_in >= trial;
    assign rem_nxt = take ? rem_in - trial : rem_in;
    assign q_nxt   = take ? (q_in | (Q_W'(1) << B)) : q_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        q_r[k]   <= q_nxt;
        ovf_r[k] <= ovf_in;
        sb_r[k]  <= sb_in;
      end
    end
  end

  assign out_vld = vld_r[Q_W-1];
  assign out_mag = ovf_r[Q_W-1] ? '1 : q_r[Q_W-1];
  assign out_sb  = sb_r[Q_W-1];

endmodule
`default_nettype wire

@@ sv/cartesian_to_spherical_jacobian.sv @@
// cartesian_to_spherical_jacobian: top level, magnitudes and products,
// square root of x^2+y^2, denominators, eight dividers and saturation.
// An input beat passes three input stages, CS_W root stages,
// two denominator stages, CS_W divider stages and one output register.
// Throughput: one beat per cycle unless the output is stalled; the root and
// divider pipelines retire one bit per stage. The whole pipeline holds while
// a finished beat waits. Reset (rst_n, synchronous) clears all valid bits.
`default_nettype none
module cartesian_to_spherical_jacobian
  import cs2sj_pkg::*;
#(
  parameter int FRAC_BITS = CS_FRAC_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_beat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_beat
);

  localparam int W     = CS_W;
  localparam int F     = FRAC_BITS;
  localparam int SW    = 2 * W;
  localparam int H     = W - 1;
  localparam int R2W   = 2 * W - 2;
  localparam int DENW  = 3 * W - 2;
  localparam int NUM_W = 2 * W + 2 * F;
  localparam int NDIV  = 8;

  typedef struct packed {
    logic [W-1:0]   ax;
    logic [W-1:0]   ay;
    logic [W-1:0]   az;
    logic [H-1:0]   rr;
    logic [R2W-1:0] r2;
    logic [SW-1:0]  xz;
    logic [SW-1:0]  yz;
    logic [SW-1:0]  sum;
    logic           nx;
    logic           ny;
    logic           nz;
    logic [1:0]     st;
  } sq_sb_t;

  typedef struct packed {
    logic [1:0] st;
    logic       zero;
    logic       neg;
  } div_sb_t;

  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // stage 1: magnitudes and signs
  logic           v1_r;
  logic [W-1:0]   ax1_r, ay1_r, az1_r;
  logic [H-1:0]   rr1_r;
  logic           nx1_r, ny1_r, nz1_r;
  logic [1:0]     st1_r;
  logic [W-1:0]   x_raw, y_raw, z_raw;
  logic [1:0]     st1_nxt;

  assign x_raw = $unsigned(in_beat.coord_x);
  assign y_raw = $unsigned(in_beat.coord_y);
  assign z_raw = $unsigned(in_beat.coord_z);
  assign st1_nxt = ((in_beat.radius == '0) ? ST_RADIUS_ZERO : ST_OK)
                 | (((x_raw | y_raw) == '0) ? ST_POLAR_AXIS : ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx1_r <= x_raw[W-1];
      ny1_r <= y_raw[W-1];
      nz1_r <= z_raw[W-1];
      ax1_r <= x_raw[W-1] ? (~x_raw + 1'b1) : x_raw;
      ay1_r <= y_raw[W-1] ? (~y_raw + 1'b1) : y_raw;
      az1_r <= z_raw[W-1] ? (~z_raw + 1'b1) : z_raw;
      rr1_r <= in_beat.radius;
      st1_r <= st1_nxt;
    end
  end

  // stage 2: products
  logic           v2_r;
  logic [W-1:0]   ax2_r, ay2_r, az2_r;
  logic [H-1:0]   rr2_r;
  logic [SW-1:0]  xx2_r, yy2_r, xz2_r, yz2_r;
  logic [R2W-1:0] r22_r;
  logic           nx2_r, ny2_r, nz2_r;
  logic [1:0]     st2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax2_r <= ax1_r;
      ay2_r <= ay1_r;
      az2_r <= az1_r;
      rr2_r <= rr1_r;
      xx2_r <= SW'(ax1_r) * SW'(ax1_r);
      yy2_r <= SW'(ay1_r) * SW'(ay1_r);
      xz2_r <= SW'(ax1_r) * SW'(az1_r);
      yz2_r <= SW'(ay1_r) * SW'(az1_r);
      r22_r <= R2W'(rr1_r) * R2W'(rr1_r);
      nx2_r <= nx1_r;
      ny2_r <= ny1_r;
      nz2_r <= nz1_r;
      st2_r <= st1_r;
    end
  end

  // stage 3: x^2 + y^2
  logic   v3_r;
  sq_sb_t sb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb3_r.ax  <= ax2_r;
      sb3_r.ay  <= ay2_r;
      sb3_r.az  <= az2_r;
      sb3_r.rr  <= rr2_r;
      sb3_r.r2  <= r22_r;
      sb3_r.xz  <= xz2_r;
      sb3_r.yz  <= yz2_r;
      sb3_r.sum <= xx2_r + yy2_r;
      sb3_r.nx  <= nx2_r;
      sb3_r.ny  <= ny2_r;
      sb3_r.nz  <= nz2_r;
      sb3_r.st  <= st2_r;
    end
  end

  // rho
  logic         sq_vld;
  logic [W-1:0] sq_root;
  sq_sb_t       sq_sb;

  cs2sj_sqrt #(
    .SQ_W  (SW),
    .RES_W (W),
    .SB_W  ($bits(sq_sb_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (v3_r),
    .in_s     (sb3_r.sum),
    .in_sb    (sb3_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_sb   (sq_sb)
  );

  // stage 4: rho * r^2 split in two partial products
  logic         v4_r;
  logic [W-1:0] rho4_r;
  logic [W+H-1:0] plo4_r, phi4_r;
  sq_sb_t       sb4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rho4_r <= sq_root;
      plo4_r <= (W+H)'(sq_root) * (W+H)'(sq_sb.r2[H-1:0]);
      phi4_r <= (W+H)'(sq_root) * (W+H)'(sq_sb.r2[R2W-1:H]);
      sb4_r  <= sq_sb;
    end
  end

  // stage 5: divider operands
  logic            v5_r;
  logic [NUM_W-1:0] num5_r [NDIV];
  logic [DENW-1:0]  den5_r [NDIV];
  div_sb_t          dsb5_r [NDIV];

  logic [NUM_W-1:0] num_nxt [NDIV];
  logic [DENW-1:0]  den_nxt [NDIV];
  div_sb_t          dsb_nxt [NDIV];
  logic [DENW-1:0]  den_rho;
  logic             rz4, oa4;

  assign den_rho = DENW'(plo4_r) + (DENW'(phi4_r) << H);
  assign rz4     = |(sb4_r.st & ST_RADIUS_ZERO);
  assign oa4     = |(sb4_r.st & ST_POLAR_AXIS);

  always_comb begin
    // dr_dx, dtheta_dx, dphi_dx
    num_nxt[0] = NUM_W'(sb4_r.ax) << F;
    den_nxt[0] = DENW'(sb4_r.rr);
    dsb_nxt[0] = '{st: sb4_r.st, zero: rz4, neg: sb4_r.nx};
    num_nxt[1] = NUM_W'(sb4_r.xz) << (2 * F);
    den_nxt[1] = den_rho;
    dsb_nxt[1] = '{st: sb4_r.st, zero: rz4 | oa4, neg: sb4_r.nx ^ sb4_r.nz};
    num_nxt[2] = NUM_W'(sb4_r.ay) << (2 * F);
    den_nxt[2] = DENW'(sb4_r.sum);
    dsb_nxt[2] = '{st: sb4_r.st, zero: oa4, neg: !sb4_r.ny};
    // dr_dy, dtheta_dy, dphi_dy
    num_nxt[3] = NUM_W'(sb4_r.ay) << F;
    den_nxt[3] = DENW'(sb4_r.rr);
    dsb_nxt[3] = '{st: sb4_r.st, zero: rz4, neg: sb4_r.ny};
    num_nxt[4] = NUM_W'(sb4_r.yz) << (2 * F);
    den_nxt[4] = den_rho;
    dsb_nxt[4] = '{st: sb4_r.st, zero: rz4 | oa4, neg: sb4_r.ny ^ sb4_r.nz};
    num_nxt[5] = NUM_W'(sb4_r.ax) << (2 * F);
    den_nxt[5] = DENW'(sb4_r.sum);
    dsb_nxt[5] = '{st: sb4_r.st, zero: oa4, neg: sb4_r.nx};
    // dr_dz, dtheta_dz
    num_nxt[6] = NUM_W'(sb4_r.az) << F;
    den_nxt[6] = DENW'(sb4_r.rr);
    dsb_nxt[6] = '{st: sb4_r.st, zero: rz4, neg: sb4_r.nz};
    num_nxt[7] = NUM_W'(rho4_r) << (2 * F);
    den_nxt[7] = DENW'(sb4_r.r2);
    dsb_nxt[7] = '{st: sb4_r.st, zero: rz4, neg: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NDIV; j++) begin
        num5_r[j] <= num_nxt[j];
        den5_r[j] <= den_nxt[j];
        dsb5_r[j] <= dsb_nxt[j];
      end
    end
  end

  // dividers
  logic          dv_vld [NDIV];
  logic [W-1:0]  dv_mag [NDIV];
  div_sb_t       dv_sb  [NDIV];
  logic [W-1:0]  res    [NDIV];

  localparam logic [W-1:0] LIM = {1'b1, {(W-1){1'b0}}};

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    cs2sj_div #(
      .NUM_W (NUM_W),
      .DEN_W (DENW),
      .Q_W   (W),
      .SB_W  ($bits(div_sb_t))
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .in_vld  (v5_r),
      .in_num  (num5_r[j]),
      .in_den  (den5_r[j]),
      .in_sb   (dsb5_r[j]),
      .out_vld (dv_vld[j]),
      .out_mag (dv_mag[j]),
      .out_sb  (dv_sb[j])
    );

    // saturate to the signed word range
    always_comb begin
      if (dv_sb[j].zero) begin
        res[j] = '0;
      end else if (dv_sb[j].neg) begin
        res[j] = dv_mag[j][W-1] ? LIM : (~dv_mag[j] + 1'b1);
      end else begin
        res[j] = dv_mag[j][W-1] ? ~LIM : dv_mag[j];
      end
    end
  end

  // output register
  out_beat_t out_r;
  out_beat_t out_nxt;

  always_comb begin
    out_nxt.dr_dx     = res[0];
    out_nxt.dtheta_dx = res[1];
    out_nxt.dphi_dx   = res[2];
    out_nxt.dr_dy     = res[3];
    out_nxt.dtheta_dy = res[4];
    out_nxt.dphi_dy   = res[5];
    out_nxt.dr_dz     = res[6];
    out_nxt.dtheta_dz = res[7];
    out_nxt.status    = dv_sb[0].st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

endmodule
`default_nettype wire

@@ test/tb_cartesian_to_spherical_jacobian.sv @@
// tb_cartesian_to_spherical_jacobian: random and directed test of the jacobian block,
// checked beat by beat against an exact wide-integer predictor.
// Depends on cs2sj_pkg and cartesian_to_spherical_jacobian.
`timescale 1ns / 100ps
`default_nettype none
module tb_cartesian_to_spherical_jacobian;
  import cs2sj_pkg::*;

  localparam int FRAC = CS_FRAC_DEF;
  localparam int N_RANDOM = 1200;
  localparam int STALL_LIMIT = 3000;
  localparam bit [127:0] SAT_LIM = 128'h8000_0000;

  class jacobian_scoreboard;
    out_beat_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function bit [31:0] sat_quot(bit [127:0] num, bit [127:0] den, bit neg);
      bit [127:0] q;
      if (den == 0) return 32'd0;
      q = num / den;
      if (q >= SAT_LIM) return neg ? 32'h8000_0000 : 32'h7fff_ffff;
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function void note_input(in_beat_t b);
      out_beat_t e;
      bit [31:0] ax, ay, az;
      bit [127:0] bx, by, bz, br, sum, r2, rho, den;
      bit [63:0] root, c;
      bit nx, ny, nz, r_zero, on_axis;
      nx = b.coord_x[CS_W-1];
      ny = b.coord_y[CS_W-1];
      nz = b.coord_z[CS_W-1];
      ax = nx ? -b.coord_x : b.coord_x;
      ay = ny ? -b.coord_y : b.coord_y;
      az = nz ? -b.coord_z : b.coord_z;
      bx = ax; by = ay; bz = az; br = b.radius;
      sum = bx * bx + by * by;
      root = 0;
      for (int k = 31; k >= 0; k--) begin
        c = root | (64'd1 << k);
        if (c * c <= sum[63:0]) root = c;
      end
      rho = root;
      r2 = br * br;
      r_zero = (b.radius == 0);
      on_axis = (ax == 0) && (ay == 0);
      e = '0;
      if (!r_zero) begin
        e.dr_dx = sat_quot(bx << FRAC, br, nx);
        e.dr_dy = sat_quot(by << FRAC, br, ny);
        e.dr_dz = sat_quot(bz << FRAC, br, nz);
        e.dtheta_dz = sat_quot(rho << (2 * FRAC), r2, 1'b1);
        if (!on_axis) begin
          den = rho * r2;
          e.dtheta_dx = sat_quot((bx * bz) << (2 * FRAC), den, nx ^ nz);
          e.dtheta_dy = sat_quot((by * bz) << (2 * FRAC), den, ny ^ nz);
        end
      end
      if (!on_axis) begin
        e.dphi_dx = sat_quot(by << (2 * FRAC), sum, !ny);
        e.dphi_dy = sat_quot(bx << (2 * FRAC), sum, nx);
      end
      e.status = ST_OK;
      if (r_zero) e.status = e.status | ST_RADIUS_ZERO;
      if (on_axis) e.status = e.status | ST_POLAR_AXIS;
      pending.push_back(e);
    endfunction

    function void check_result(out_beat_t a);
      out_beat_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.dr_dx !== e.dr_dx) begin
        $error("dr_dx exp %h got %h", e.dr_dx, a.dr_dx); errors++;
      end
      if (a.dtheta_dx !== e.dtheta_dx) begin
        $error("dtheta_dx exp %h got %h", e.dtheta_dx, a.dtheta_dx); errors++;
      end
      if (a.dphi_dx !== e.dphi_dx) begin
        $error("dphi_dx exp %h got %h", e.dphi_dx, a.dphi_dx); errors++;
      end
      if (a.dr_dy !== e.dr_dy) begin
        $error("dr_dy exp %h got %h", e.dr_dy, a.dr_dy); errors++;
      end
      if (a.dtheta_dy !== e.dtheta_dy) begin
        $error("dtheta_dy exp %h got %h", e.dtheta_dy, a.dtheta_dy); errors++;
      end
      if (a.dphi_dy !== e.dphi_dy) begin
        $error("dphi_dy exp %h got %h", e.dphi_dy, a.dphi_dy); errors++;
      end
      if (a.dr_dz !== e.dr_dz) begin
        $error("dr_dz exp %h got %h", e.dr_dz, a.dr_dz); errors++;
      end
      if (a.dtheta_dz !== e.dtheta_dz) begin
        $error("dtheta_dz exp %h got %h", e.dtheta_dz, a.dtheta_dz); errors++;
      end
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_beat = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_beat;

  jacobian_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  bit finished = 1'b0;
  int stall_cycles = 0;

  cartesian_to_spherical_jacobian u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_beat(in_beat),
    .out_valid(out_valid), .out_ready(out_ready), .out_beat(out_beat)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_beat);
      if (in_valid && in_ready) sb.note_input(in_beat);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (!finished && stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int hold;
    int n;
    hold = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send(in_beat_t b);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [30:0] r);
    in_beat_t b;
    b.coord_x = x;
    b.coord_y = y;
    b.coord_z = z;
    b.radius = r;
    send(b);
  endtask

  function automatic logic [31:0] pick_coord(int shape);
    logic [31:0] v;
    case (shape)
      0: v = $urandom();
      1: v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: v = 32'd0;
      default: v = $urandom() >>> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] x, y, z;
    logic [30:0] r;
    int shape;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero radius, polar axis, both, saturation
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'd1);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 31'd0);
    send_point(32'd0, 32'd0, 32'h0005_0000, 31'h0005_0000);
    send_point(32'd0, 32'd0, 32'hfffb_0000, 31'd0);
    send_point(32'd0, 32'd0, 32'd0, 31'd0);
    send_point(32'd1, 32'd0, 32'd0, 31'd1);
    send_point(32'd0, 32'hffff_ffff, 32'd0, 31'h7fff_ffff);
    send_point(32'h0003_0000, 32'h0004_0000, 32'd0, 31'h0005_0000);
    send_point(32'hfffd_0000, 32'h0004_0000, 32'hfff4_0000, 31'h000d_0000);
    send_point(32'h8000_0000, 32'd0, 32'd0, 31'h7fff_ffff);
    send_point(32'd1, 32'd1, 32'h8000_0000, 31'd1);
    send_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h4000_0000);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 400) hold_request = 1'b1;
      if (i == N_RANDOM - 200) quiet = 1'b1;
      shape = $urandom_range(0, 9);
      x = pick_coord(shape % 4);
      y = pick_coord((shape + $urandom_range(0, 3)) % 4);
      z = pick_coord($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0: r = 31'd0;
        1: r = $urandom_range(1, 255);
        2: r = $urandom();
        default: r = $urandom() >> $urandom_range(1, 30);
      endcase
      send_point(x, y, z, r);
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    finished = 1'b1;
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ cartesian_to_spherical_jacobian.f @@
sv/cs2sj_pkg.sv
sv/cs2sj_sqrt.sv
sv/cs2sj_div.sv
sv/cartesian_to_spherical_jacobian.sv
test/tb_cartesian_to_spherical_jacobian.sv
